// File: sv/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and constants of the strict priority multi-level queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spmq_pkg;

  // queue geometry, queue depth is a power of two so the pointers wrap freely
  localparam int LEVELS      = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int LEVEL_W     = 3;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = LEVEL_W + PTR_W;
  localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int PAYLOAD_W   = 16;
  localparam int COUNT_W     = 4;

  // operation codes
  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // input item
  typedef struct packed {
    func_t                  func;
    logic [LEVEL_W-1:0]     level;
    logic [PAYLOAD_W-1:0]   payload;
  } cmd_t;

  // result item
  typedef struct packed {
    status_t                status;
    logic [LEVEL_W-1:0]     out_level;
    logic [PAYLOAD_W-1:0]   out_payload;
  } result_t;

  // access to the item store
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [PAYLOAD_W-1:0]   wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  // registered result of the control path, payload comes from the store
  typedef struct packed {
    logic                   done;
    status_t                status;
    logic [LEVEL_W-1:0]     out_level;
    logic                   use_rdata;
  } ctrl_resp_t;

  // observation of the control state
  typedef struct packed {
    logic [LEVELS-1:0]      ready_bits;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// File: sv/spmq_store.sv
// ----------------------------------------------------------------------------
// spmq_store
// Item store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spmq_store (
  input  wire logic                       clk,
  input  wire spmq_pkg::mem_req_t         req,
  output logic [spmq_pkg::PAYLOAD_W-1:0]  rdata
);

  logic [spmq_pkg::PAYLOAD_W-1:0] mem [spmq_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/spmq_ctrl.sv
// ----------------------------------------------------------------------------
// spmq_ctrl
// Queue pointers, fill counts and ready bitmap; picks the level to serve and
// drives the item store.
// ----------------------------------------------------------------------------
`default_nettype none

module spmq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire spmq_pkg::cmd_t                cmd,
  input  wire logic [spmq_pkg::COUNT_W-1:0]  level_count,
  output logic                               busy,
  output spmq_pkg::mem_req_t                 mem_req,
  output spmq_pkg::ctrl_resp_t               resp,
  output spmq_pkg::ctrl_stat_t               stat
);

  logic [spmq_pkg::PTR_W-1:0]   head_index [spmq_pkg::LEVELS];
  logic [spmq_pkg::PTR_W-1:0]   tail_index [spmq_pkg::LEVELS];
  logic [spmq_pkg::FILL_W-1:0]  fill_count [spmq_pkg::LEVELS];
  logic [spmq_pkg::LEVELS-1:0]  ready_bits;

  logic                          go;
  logic [spmq_pkg::COUNT_W-1:0]  limit;
  logic                          in_range;
  logic                          is_full;
  logic                          push_ok;
  logic                          any_ready;
  logic [spmq_pkg::LEVEL_W-1:0]  sel;
  logic                          pop_ok;
  spmq_pkg::status_t             status_next;

  assign go = start && !busy;

  // clamp the level count to the number of levels built
  assign limit = (level_count > spmq_pkg::COUNT_W'(spmq_pkg::LEVELS)) ?
                 spmq_pkg::COUNT_W'(spmq_pkg::LEVELS) : level_count;
  assign in_range = {1'b0, cmd.level} < limit;
  assign is_full  = fill_count[cmd.level] >= spmq_pkg::FILL_W'(spmq_pkg::QUEUE_DEPTH);
  assign push_ok  = in_range && !is_full;

  // lowest set bit of the ready bitmap
  always_comb begin
    sel = '0;
    for (int i = spmq_pkg::LEVELS - 1; i >= 0; i--) begin
      if (ready_bits[i]) begin
        sel = spmq_pkg::LEVEL_W'(i);
      end
    end
  end
  assign any_ready = |ready_bits;
  assign pop_ok    = any_ready && (fill_count[sel] != '0);

  // status of the item being accepted
  always_comb begin
    if (cmd.func == spmq_pkg::FUNC_PUSH) begin
      if (!in_range) begin
        status_next = spmq_pkg::ST_RANGE;
      end else if (is_full) begin
        status_next = spmq_pkg::ST_FULL;
      end else begin
        status_next = spmq_pkg::ST_OK;
      end
    end else begin
      status_next = pop_ok ? spmq_pkg::ST_OK : spmq_pkg::ST_EMPTY;
    end
  end

  // store access: push writes at the tail, pop reads at the head
  always_comb begin
    mem_req.we    = go && (cmd.func == spmq_pkg::FUNC_PUSH) && push_ok;
    mem_req.waddr = {cmd.level, tail_index[cmd.level]};
    mem_req.wdata = cmd.payload;
    mem_req.re    = go && (cmd.func == spmq_pkg::FUNC_POP) && pop_ok;
    mem_req.raddr = {sel, head_index[sel]};
  end

  // pointer, count and bitmap update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spmq_pkg::LEVELS; i++) begin
        head_index[i] <= '0;
        tail_index[i] <= '0;
        fill_count[i] <= '0;
      end
      ready_bits <= '0;
    end else if (mem_req.we) begin
      tail_index[cmd.level] <= tail_index[cmd.level] + 1'b1;
      fill_count[cmd.level] <= fill_count[cmd.level] + 1'b1;
      ready_bits[cmd.level] <= 1'b1;
    end else if (mem_req.re) begin
      head_index[sel] <= head_index[sel] + 1'b1;
      fill_count[sel] <= fill_count[sel] - 1'b1;
      if (fill_count[sel] == spmq_pkg::FILL_W'(1)) begin
        ready_bits[sel] <= 1'b0;
      end
    end
  end

  // busy only in the cycle after reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // result strobe and fields
  always_ff @(posedge clk) begin
    if (rst) begin
      resp.done <= 1'b0;
    end else begin
      resp.done <= go;
    end
    if (go) begin
      resp.status    <= status_next;
      resp.out_level <= mem_req.re ? sel : '0;
      resp.use_rdata <= mem_req.re;
    end
  end

  assign stat.ready_bits = ready_bits;

endmodule

`default_nettype wire

// File: sv/strict_priority_multi_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Eight FIFO levels of sixteen item handles with a ready bitmap; pops serve
// the lowest-numbered non-empty level.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle whenever busy is low; busy is high only
// in the first cycle after reset. Each accepted item gives exactly one result
// in the following cycle, marked by done for one cycle; the receiver cannot
// stall it. The item store takes one write or one read each cycle, and its
// read data is registered so that a popped payload arrives together with
// the result of its pop. The item store is not cleared
// by reset. The level count register is written through cfg_valid/cfg_data and
// is always ready; write it only while no result is outstanding.
`default_nettype none

module strict_priority_multi_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire spmq_pkg::cmd_t                cmd,
  output logic                               done,
  output spmq_pkg::result_t                  result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [spmq_pkg::COUNT_W-1:0]  cfg_data
);

  logic [spmq_pkg::COUNT_W-1:0]    level_count;
  spmq_pkg::mem_req_t              mem_req;
  spmq_pkg::ctrl_resp_t            resp;
  spmq_pkg::ctrl_stat_t            stat;
  logic [spmq_pkg::PAYLOAD_W-1:0]  rdata;

  // level count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= spmq_pkg::COUNT_W'(spmq_pkg::LEVELS);
    end else if (cfg_valid && cfg_ready) begin
      level_count <= cfg_data;
    end
  end

  spmq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .level_count (level_count),
    .busy        (busy),
    .mem_req     (mem_req),
    .resp        (resp),
    .stat        (stat)
  );

  spmq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // result assembly, popped payload straight from the store read port
  assign done               = resp.done;
  assign result.status      = resp.status;
  assign result.out_level   = resp.out_level;
  assign result.out_payload = resp.use_rdata ? rdata : '0;

  // a result only follows an accepted item
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without accepted item");

  // empty is reported only when the bitmap was clear
  a_empty_bitmap: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == spmq_pkg::ST_EMPTY) |-> ($past(stat.ready_bits) == '0))
    else $error("empty reported with levels ready");

  // a range reject only comes from a push
  a_range_push: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == spmq_pkg::ST_RANGE) |-> ($past(cmd.func) == spmq_pkg::FUNC_PUSH))
    else $error("range reject on a pop");

  // a successful pop serves a level that was ready
  a_pop_level_ready: assert property (@(posedge clk) disable iff (rst)
    (done && resp.use_rdata) |-> ($past(stat.ready_bits) != '0))
    else $error("pop from empty bitmap");

endmodule

`default_nettype wire
